/* design/elp_pkg.sv */
// Shared types, constants and a helper function for the ELF64 load plan checker.
// Used by every module of the block; depends on nothing else.
package elp_pkg;

  localparam int MAX_SEGMENTS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 25;

  localparam int REC_BYTES = 56;
  localparam int HDR_BYTES = 64;

  localparam logic [31:0] PT_NULL      = 32'd0;
  localparam logic [31:0] PT_LOAD      = 32'd1;
  localparam logic [31:0] PT_NOTE      = 32'd4;
  localparam logic [31:0] PT_PHDR      = 32'd6;
  localparam logic [31:0] PT_GNU_STACK = 32'h6474e551;

  localparam logic [63:0] PAGE_MASK = 64'd4095;

  localparam logic [1:0] ACC_RO    = 2'd0;
  localparam logic [1:0] ACC_EXEC  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  localparam logic [2:0] REG_FILE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_USER_LOW    = 3'd1;
  localparam logic [2:0] REG_USER_END    = 3'd2;
  localparam logic [2:0] REG_STACK_GUARD = 3'd3;
  localparam logic [2:0] REG_STACK_TOP   = 3'd4;
  localparam logic [2:0] REG_PAGE_BUDGET = 3'd5;

  localparam logic [7:0] ELF_MAG0    = 8'h7f;
  localparam logic [7:0] ELF_MAG1    = 8'h45;
  localparam logic [7:0] ELF_MAG2    = 8'h4c;
  localparam logic [7:0] ELF_MAG3    = 8'h46;
  localparam logic [7:0] ELF_CLASS64 = 8'd2;
  localparam logic [7:0] ELF_ONE     = 8'd1;
  localparam logic [7:0] ELF_EXEC    = 8'd2;
  localparam logic [7:0] ELF_X86_64  = 8'd62;
  localparam logic [7:0] ELF_ZERO    = 8'd0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
    ST_WRD, ST_WCMP, ST_RSTORE,
    ST_FIN0, ST_FRD, ST_FCMP,
    ST_ERD, ST_EWAIT
  } state_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] off;
    logic [63:0] fsz;
    logic [63:0] msz;
    logic [63:0] pstart;
    logic [63:0] pend;
    logic [1:0]  acc;
  } seg_t;

  typedef struct packed {
    logic rec_last;   // this request completes a program header record
    logic byte_fail;  // this request rejects the image
  } cap_stat_t;

  // Expected header byte; bit 8 set means the byte is not checked.
  function automatic logic [8:0] hdr_expect(input logic [5:0] p);
    logic [8:0] e;
    e = 9'h100;
    case (p)
      6'd0:  e = {1'b0, ELF_MAG0};
      6'd1:  e = {1'b0, ELF_MAG1};
      6'd2:  e = {1'b0, ELF_MAG2};
      6'd3:  e = {1'b0, ELF_MAG3};
      6'd4:  e = {1'b0, ELF_CLASS64};
      6'd5, 6'd6: e = {1'b0, ELF_ONE};
      6'd7, 6'd8: e = {1'b0, ELF_ZERO};
      6'd16: e = {1'b0, ELF_EXEC};
      6'd18: e = {1'b0, ELF_X86_64};
      6'd20: e = {1'b0, ELF_ONE};
      6'd17, 6'd19, 6'd21, 6'd22, 6'd23: e = {1'b0, ELF_ZERO};
      6'd48, 6'd49, 6'd50, 6'd51: e = {1'b0, ELF_ZERO};
      6'd52: e = {1'b0, 8'(HDR_BYTES)};
      6'd54: e = {1'b0, 8'(REC_BYTES)};
      6'd53, 6'd55: e = {1'b0, ELF_ZERO};
      default: e = 9'h100;
    endcase
    return e;
  endfunction

endpackage

/* design/elp_seg_store.sv */
// Segment table memory: one entry per stored load segment, registered read.
// Depends on elp_pkg for the entry layout.
module elp_seg_store #(
  parameter int DEPTH = elp_pkg::MAX_SEGMENTS_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  elp_pkg::seg_t  wdata,
  input  logic           re,
  input  logic [IW-1:0]  raddr,
  output elp_pkg::seg_t  rdata
);
  import elp_pkg::*;

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/elp_capture.sv */
// Byte stream front end: position counter, header checks and capture,
// program header record assembly. Depends on elp_pkg.
module elp_capture #(
  parameter int POSITION_BITS = elp_pkg::POSITION_BITS_DEF,
  parameter int MAX_SEGMENTS  = elp_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     accept,
  input  logic                     rejected,
  input  logic [7:0]               image_byte,
  output logic [POSITION_BITS-1:0] pos,
  output logic [63:0]              entry,
  output logic [63:0]              tbl_off,
  output logic [15:0]              rec_cnt,
  output logic [447:0]             rec_bytes,
  output elp_pkg::cap_stat_t       stat
);
  import elp_pkg::*;

  logic [7:0][7:0]  entry_b;
  logic [7:0][7:0]  off_b;
  logic [1:0][7:0]  cnt_b;
  logic [55:0][7:0] rec;
  logic [5:0]       k;
  logic [6:0]       seen;

  logic       at_max, in_hdr, mismatch, hdr_end_bad, take, active;
  logic [8:0] expect_b;

  assign entry     = entry_b;
  assign tbl_off   = off_b;
  assign rec_cnt   = cnt_b;
  assign rec_bytes = rec;

  always_comb begin
    at_max      = (pos == '1);
    in_hdr      = (pos[POSITION_BITS-1:6] == '0);
    expect_b    = hdr_expect(pos[5:0]);
    mismatch    = in_hdr && !expect_b[8] && (image_byte != expect_b[7:0]);
    hdr_end_bad = in_hdr && (pos[5:0] == 6'(HDR_BYTES - 1)) &&
                  ((rec_cnt == '0) || (rec_cnt > 16'(MAX_SEGMENTS)) ||
                   (tbl_off < 64'(HDR_BYTES)));
    take        = accept && !rejected && !at_max && !mismatch;
    active      = !in_hdr && (64'(pos) >= tbl_off) && (16'(seen) < rec_cnt);
    stat.byte_fail = at_max || (!rejected && (mismatch || hdr_end_bad));
    stat.rec_last  = take && active && (k == 6'(REC_BYTES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos     <= '0;
      entry_b <= '0;
      off_b   <= '0;
      cnt_b   <= '0;
      k       <= '0;
      seen    <= '0;
    end else if (accept) begin
      if (!at_max) begin
        pos <= pos + 1'b1;
      end
      if (take) begin
        if (in_hdr) begin
          if (pos[5:3] == 3'd3) entry_b[pos[2:0]] <= image_byte;
          if (pos[5:3] == 3'd4) off_b[pos[2:0]] <= image_byte;
          if (pos[5:1] == 5'd28) cnt_b[pos[0]] <= image_byte;
        end else if (active) begin
          rec[k] <= image_byte;
          if (k == 6'(REC_BYTES - 1)) begin
            k    <= '0;
            seen <= seen + 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* design/elf64_load_plan_checker_top.sv */
// ELF64 load plan checker: top level with the record and final check sequencer.
// Depends on elp_pkg, elp_capture and elp_seg_store.
//
// Usage: image bytes arrive on the in channel (image_byte, final_byte marks the
// last byte) under valid/ready. Ordinary bytes are taken one per cycle. The last
// byte of each 56-byte program header record holds off input while the record
// is checked in ST_R0 to ST_R5 (a skipped record type leaves after ST_R0),
// then walked against each segment already stored, a read and a compare per
// segment in the segment memory, and then stored if it passes.
// The final byte starts the image size checks in ST_FIN0, then a read and a
// compare per stored segment walking the memory again. Results then leave on
// the out channel, one per load segment, each shown after its own memory read;
// a rejected image gives one result with image_ok low and run_end high.
// A result holds on the outputs while out_ready is low; no bytes are taken
// until the last result of the run is taken, after which the run state clears.
// Registers are to be written through wr_en/wr_index/wr_data while the block is
// idle; the block itself does not enforce this.
// Reset (rst, synchronous) restores register defaults and empties the run;
// the segment memory needs no clearing since only stored entries are read.
module elf64_load_plan_checker_top #(
  parameter int MAX_SEGMENTS  = elp_pkg::MAX_SEGMENTS_DEF,
  parameter int POSITION_BITS = elp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  image_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        image_ok,
  output logic        run_end,
  output logic [63:0] entry_point,
  output logic [63:0] seg_address,
  output logic [63:0] seg_file_offset,
  output logic [63:0] seg_file_bytes,
  output logic [63:0] seg_memory_bytes,
  output logic [63:0] seg_page_start,
  output logic [63:0] seg_page_end,
  output logic [1:0]  seg_access,
  output logic [31:0] pages_total,
  output logic [6:0]  segments_total,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [48:0] wr_data
);
  import elp_pkg::*;

  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SZW = POSITION_BITS + 1;

  // configuration
  logic [24:0] file_limit;
  logic [47:0] user_low;
  logic [48:0] user_end, stack_guard, stack_top;
  logic [31:0] page_budget;

  state_t state, state_next;

  logic          rejected, fin_pend, ok, eie, fail, hit, clear_run;
  logic [CW-1:0] stored, j;
  logic [31:0]   page_sum;
  logic [SZW-1:0] size;
  logic [63:0]   amask, room, psum, pend, pages;
  logic          accept, mem_re, mem_we, last_j;
  seg_t          rdata, wdata;

  logic [POSITION_BITS-1:0] pos;
  logic [63:0]   entry, tbl_off;
  logic [15:0]   rec_cnt;
  logic [447:0]  rec_bytes;
  cap_stat_t     cs;

  logic [31:0] rtype, rflags;
  logic [63:0] r_off, r_addr, r_fsz, r_msz, r_align, pstart, size64;
  logic        skip, f0, f1, f2, f3, f4, overlap, fin_fail, fbad;

  assign accept = in_valid && in_ready;

  elp_capture #(
    .POSITION_BITS(POSITION_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear_run),
    .accept    (accept),
    .rejected  (rejected),
    .image_byte(image_byte),
    .pos       (pos),
    .entry     (entry),
    .tbl_off   (tbl_off),
    .rec_cnt   (rec_cnt),
    .rec_bytes (rec_bytes),
    .stat      (cs)
  );

  elp_seg_store #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(stored[IW-1:0]),
    .wdata(wdata),
    .re   (mem_re),
    .raddr(j[IW-1:0]),
    .rdata(rdata)
  );

  // record field decode and per-step checks
  always_comb begin
    rtype   = rec_bytes[31:0];
    rflags  = rec_bytes[63:32];
    r_off   = rec_bytes[127:64];
    r_addr  = rec_bytes[191:128];
    r_fsz   = rec_bytes[319:256];
    r_msz   = rec_bytes[383:320];
    r_align = rec_bytes[447:384];
    pstart  = r_addr & ~PAGE_MASK;
    size64  = 64'(size);
    skip = (rtype == PT_NULL) || (rtype == PT_NOTE) || (rtype == PT_PHDR) ||
           (rtype == PT_GNU_STACK);
    f0 = (rtype != PT_LOAD) || (r_msz == '0) || (r_fsz > r_msz) ||
         (rflags[31:3] != '0) || !rflags[2] || (rflags[1:0] == 2'b11) ||
         (r_addr[11:0] != r_off[11:0]);
    f1 = (r_addr < 64'(user_low)) || (r_addr >= 64'(user_end));
    f2 = (r_msz > room) ||
         ((r_align > 64'd1) && (((r_align & amask) != '0) ||
                                ((r_addr & amask) != (r_off & amask))));
    f3 = (pstart < 64'(stack_top)) && ((psum & ~PAGE_MASK) > 64'(stack_guard));
    f4 = (page_sum > page_budget) || (pages > 64'(page_budget - page_sum));
    overlap  = (pstart < rdata.pend) && (pend > rdata.pstart);
    fin_fail = rejected || (size < SZW'(HDR_BYTES)) || (size64 > 64'(file_limit)) ||
               (tbl_off > size64) ||
               (22'(rec_cnt) * 22'(REC_BYTES) > 22'(size64 - tbl_off) &&
                ((size64 - tbl_off) < 64'(1 << 22))) ||
               (stored == '0);
    fbad = (rdata.off > size64) || (rdata.fsz > size64 - rdata.off);
    last_j = ((j + CW'(1)) == stored);
    wdata.addr   = r_addr;
    wdata.off    = r_off;
    wdata.fsz    = r_fsz;
    wdata.msz    = r_msz;
    wdata.pstart = pstart;
    wdata.pend   = pend;
    wdata.acc    = rflags[1] ? ACC_WRITE : (rflags[0] ? ACC_EXEC : ACC_RO);
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    clear_run  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cs.rec_last) state_next = ST_R0;
          else if (final_byte) state_next = ST_FIN0;
        end
      end
      ST_R0: state_next = skip ? (fin_pend ? ST_FIN0 : ST_IDLE) : ST_R1;
      ST_R1: state_next = ST_R2;
      ST_R2: state_next = ST_R3;
      ST_R3: state_next = ST_R4;
      ST_R4: state_next = ST_R5;
      ST_R5: begin
        if (fail) state_next = fin_pend ? ST_FIN0 : ST_IDLE;
        else if (stored == '0) state_next = ST_RSTORE;
        else state_next = ST_WRD;
      end
      ST_WRD: begin
        mem_re     = 1'b1;
        state_next = ST_WCMP;
      end
      ST_WCMP: begin
        if (overlap) state_next = fin_pend ? ST_FIN0 : ST_IDLE;
        else if (last_j) state_next = ST_RSTORE;
        else state_next = ST_WRD;
      end
      ST_RSTORE: begin
        mem_we     = (stored < CW'(MAX_SEGMENTS));
        state_next = fin_pend ? ST_FIN0 : ST_IDLE;
      end
      ST_FIN0: state_next = fin_fail ? ST_EWAIT : ST_FRD;
      ST_FRD: begin
        mem_re     = 1'b1;
        state_next = ST_FCMP;
      end
      ST_FCMP: begin
        if (fbad) state_next = ST_EWAIT;
        else if (last_j) state_next = eie ? ST_ERD : ST_EWAIT;
        else state_next = ST_FRD;
      end
      ST_ERD: begin
        mem_re     = 1'b1;
        state_next = ST_EWAIT;
      end
      ST_EWAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (run_end) begin
            clear_run  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ERD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rejected    <= 1'b0;
      fin_pend    <= 1'b0;
      ok          <= 1'b0;
      eie         <= 1'b0;
      stored      <= '0;
      page_sum    <= '0;
      j           <= '0;
      file_limit  <= 25'd16777216;
      user_low    <= 48'd65536;
      user_end    <= 49'd140737488355328;
      stack_guard <= 49'd140737479966720;
      stack_top   <= 49'd140737488351232;
      page_budget <= 32'd262144;
    end else begin
      state <= state_next;
      if (wr_en) begin
        case (wr_index)
          REG_FILE_LIMIT:  file_limit  <= wr_data[24:0];
          REG_USER_LOW:    user_low    <= wr_data[47:0];
          REG_USER_END:    user_end    <= wr_data;
          REG_STACK_GUARD: stack_guard <= wr_data;
          REG_STACK_TOP:   stack_top   <= wr_data;
          REG_PAGE_BUDGET: page_budget <= wr_data[31:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fin_pend <= final_byte;
            size     <= SZW'(pos) + SZW'(1);
            if (cs.byte_fail) rejected <= 1'b1;
          end
        end
        ST_R0: begin
          if (skip && (rtype == PT_GNU_STACK) && rflags[0]) rejected <= 1'b1;
          fail  <= f0;
          amask <= r_align - 64'd1;
        end
        ST_R1: begin
          fail <= fail | f1;
          room <= 64'(user_end) - r_addr;
        end
        ST_R2: begin
          fail <= fail | f2;
          psum <= r_addr + r_msz + PAGE_MASK;
        end
        ST_R3: begin
          fail  <= fail | f3;
          pend  <= psum & ~PAGE_MASK;
          pages <= ((psum & ~PAGE_MASK) - pstart) >> 12;
        end
        ST_R4: begin
          fail <= fail | f4;
          hit  <= rflags[0] && (entry >= r_addr) && ((entry - r_addr) < r_fsz);
        end
        ST_R5: begin
          if (fail) rejected <= 1'b1;
          j <= '0;
        end
        ST_WCMP: begin
          if (overlap) rejected <= 1'b1;
          j <= j + CW'(1);
        end
        ST_RSTORE: begin
          if (stored < CW'(MAX_SEGMENTS)) begin
            stored   <= stored + CW'(1);
            page_sum <= page_sum + pages[31:0];
            if (hit) eie <= 1'b1;
          end else begin
            rejected <= 1'b1;
          end
        end
        ST_FIN0: begin
          ok <= 1'b0;
          j  <= '0;
        end
        ST_FCMP: begin
          if (!fbad && last_j) begin
            ok <= eie;
            j  <= '0;
          end else begin
            j <= j + CW'(1);
          end
        end
        ST_EWAIT: begin
          if (out_ready) begin
            if (run_end) begin
              rejected <= 1'b0;
              fin_pend <= 1'b0;
              eie      <= 1'b0;
              stored   <= '0;
              page_sum <= '0;
              ok       <= 1'b0;
            end else begin
              j <= j + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result fields; a rejected result shows zeros
  always_comb begin
    image_ok         = ok;
    run_end          = ok ? last_j : 1'b1;
    entry_point      = ok ? entry : '0;
    seg_address      = ok ? rdata.addr : '0;
    seg_file_offset  = ok ? rdata.off : '0;
    seg_file_bytes   = ok ? rdata.fsz : '0;
    seg_memory_bytes = ok ? rdata.msz : '0;
    seg_page_start   = ok ? rdata.pstart : '0;
    seg_page_end     = ok ? rdata.pend : '0;
    seg_access       = ok ? rdata.acc : ACC_RO;
    pages_total      = ok ? page_sum : '0;
    segments_total   = ok ? 7'(stored) : '0;
  end

  a_no_overlap_channels: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("byte taken while a result is pending");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CW'(MAX_SEGMENTS))
    else $error("segment count past table depth");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && run_end) |=> (stored == '0 && !rejected && in_ready))
    else $error("run state not cleared after last result");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !image_ok) |-> (run_end && segments_total == '0 && entry_point == '0))
    else $error("rejected result carries segment data");

  a_ok_needs_segment: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_ok) |-> (stored != '0 && eie))
    else $error("valid plan without an executable entry segment");

endmodule
